// ----- rtl/cpcr_pkg.sv -----
// Shared types, constants and helpers for the circle pair collision response.
// No dependencies; imported by every module of the block.
`default_nettype none

package cpcr_pkg;

  localparam int CFG_W        = 24;

  // Square root: one result bit per stage.
  localparam int SQRT_STAGES  = 32;
  localparam int SQ_IN_W      = 64;
  localparam int ROOT_W       = 32;
  localparam int SQ_REM_W     = ROOT_W + 3;

  // Restoring divider: one quotient bit per stage, four lanes.
  localparam int DIV_STAGES   = 18;
  localparam int DIV_LANES    = 4;
  localparam int DIV_NUM_W    = 49;
  localparam int DIV_DEN_W    = 33;
  localparam int DIV_REM_W    = DIV_DEN_W + 1;

  localparam int LANE_NX      = 0;
  localparam int LANE_NY      = 1;
  localparam int LANE_FA      = 2;
  localparam int LANE_FB      = 3;

  // Magnitude of a normal component or a mass fraction (0 .. 1.0 in Q16.16).
  localparam int NMAG_W       = 17;
  localparam logic [NMAG_W-1:0] Q_ONE = NMAG_W'(65536);

  localparam logic [CFG_W-1:0] CONTACT_SLOP_RST     = CFG_W'(72090);
  localparam logic [CFG_W-1:0] RESTITUTION_GAIN_RST = CFG_W'(74711);
  localparam logic [CFG_W-1:0] BIAS_GAIN_RST        = CFG_W'(131072);

  typedef enum logic [1:0] {
    REG_CONTACT_SLOP     = 2'd0,
    REG_RESTITUTION_GAIN = 2'd1,
    REG_BIAS_GAIN        = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] apx;
    logic signed [31:0] apy;
    logic signed [31:0] avx;
    logic signed [31:0] avy;
    logic signed [31:0] bpx;
    logic signed [31:0] bpy;
    logic signed [31:0] bvx;
    logic signed [31:0] bvy;
  } cpcr_body_t;

  // Carried alongside the square root.
  typedef struct packed {
    cpcr_body_t  body;
    logic [32:0] rsum;
    logic [30:0] am;
    logic [30:0] bm;
    logic [32:0] ux;
    logic [32:0] uy;
    logic        dx_neg;
    logic        dy_neg;
    logic        shift;
  } cpcr_geom_t;

  // Carried alongside the dividers.
  typedef struct packed {
    cpcr_body_t         body;
    logic signed [34:0] pen;
    logic               zero_dist;
    logic               dx_neg;
    logic               dy_neg;
    logic               msum_zero;
  } cpcr_cont_t;

  typedef struct packed {
    logic zero_dist;
    logic pen_neg;
    logic dx_neg;
    logic dy_neg;
    logic closing;
  } cpcr_flags_t;

  typedef struct packed {
    cpcr_body_t body;
    logic       overlapping;
    logic       impulse;
  } cpcr_result_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (&v[63:31] || ~|v[63:31]) begin
      return v[31:0];
    end else if (v[63]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cpcr_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, side payload carried along.
// Depends on cpcr_pkg.
`default_nettype none

module cpcr_sqrt (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [cpcr_pkg::SQ_IN_W-1:0]         in_radicand,
  input  cpcr_pkg::cpcr_geom_t                 in_side,
  output logic                                 out_valid,
  output logic [cpcr_pkg::ROOT_W-1:0]          out_root,
  output cpcr_pkg::cpcr_geom_t                 out_side
);
  import cpcr_pkg::*;

  logic                vld   [SQRT_STAGES];
  logic [SQ_IN_W-1:0]  rad   [SQRT_STAGES];
  logic [SQ_REM_W-1:0] rem   [SQRT_STAGES];
  logic [ROOT_W-1:0]   root  [SQRT_STAGES];
  cpcr_geom_t          side  [SQRT_STAGES];

  logic [SQ_IN_W-1:0]  rad_src  [SQRT_STAGES];
  logic [SQ_REM_W-1:0] rem_src  [SQRT_STAGES];
  logic [ROOT_W-1:0]   root_src [SQRT_STAGES];
  logic [SQ_REM_W-1:0] acc      [SQRT_STAGES];
  logic [SQ_REM_W-1:0] trial    [SQRT_STAGES];
  logic                take     [SQRT_STAGES];

  always_comb begin
    rad_src[0]  = in_radicand;
    rem_src[0]  = '0;
    root_src[0] = '0;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      rad_src[k]  = rad[k-1];
      rem_src[k]  = rem[k-1];
      root_src[k] = root[k-1];
    end
    for (int k = 0; k < SQRT_STAGES; k++) begin
      acc[k]   = {rem_src[k][SQ_REM_W-3:0], rad_src[k][SQ_IN_W-1 -: 2]};
      trial[k] = SQ_REM_W'({root_src[k], 2'b01});
      take[k]  = (acc[k] >= trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQRT_STAGES; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < SQRT_STAGES; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int k = 1; k < SQRT_STAGES; k++) side[k] <= side[k-1];
      for (int k = 0; k < SQRT_STAGES; k++) begin
        rad[k]  <= {rad_src[k][SQ_IN_W-3:0], 2'b00};
        rem[k]  <= take[k] ? (acc[k] - trial[k]) : acc[k];
        root[k] <= {root_src[k][ROOT_W-2:0], take[k]};
      end
    end
  end

  assign out_valid = vld[SQRT_STAGES-1];
  assign out_root  = root[SQRT_STAGES-1];
  assign out_side  = side[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/cpcr_div.sv -----
// Four-lane pipelined restoring divider, one quotient bit per stage.
// Depends on cpcr_pkg.
`default_nettype none

module cpcr_div (
  input  logic                                                      clk,
  input  logic                                                      rst,
  input  logic                                                      en,
  input  logic                                                      in_valid,
  input  logic [cpcr_pkg::DIV_LANES-1:0][cpcr_pkg::DIV_NUM_W-1:0]   in_num,
  input  logic [cpcr_pkg::DIV_LANES-1:0][cpcr_pkg::DIV_DEN_W-1:0]   in_den,
  input  cpcr_pkg::cpcr_cont_t                                      in_side,
  output logic                                                      out_valid,
  output logic [cpcr_pkg::DIV_LANES-1:0][cpcr_pkg::DIV_STAGES-1:0]  out_quo,
  output cpcr_pkg::cpcr_cont_t                                      out_side
);
  import cpcr_pkg::*;

  logic                                  vld  [DIV_STAGES];
  cpcr_cont_t                            side [DIV_STAGES];
  logic [DIV_LANES-1:0][DIV_REM_W-1:0]   rem  [DIV_STAGES];
  logic [DIV_LANES-1:0][DIV_STAGES-1:0]  low  [DIV_STAGES];
  logic [DIV_LANES-1:0][DIV_STAGES-1:0]  quo  [DIV_STAGES];
  logic [DIV_LANES-1:0][DIV_DEN_W-1:0]   den  [DIV_STAGES];

  logic [DIV_LANES-1:0][DIV_REM_W-1:0]   rem_src [DIV_STAGES];
  logic [DIV_LANES-1:0][DIV_STAGES-1:0]  low_src [DIV_STAGES];
  logic [DIV_LANES-1:0][DIV_STAGES-1:0]  quo_src [DIV_STAGES];
  logic [DIV_LANES-1:0][DIV_DEN_W-1:0]   den_src [DIV_STAGES];
  logic [DIV_LANES-1:0][DIV_REM_W-1:0]   acc     [DIV_STAGES];
  logic [DIV_LANES-1:0]                  take    [DIV_STAGES];

  always_comb begin
    // numerator bits above the quotient field are known to be below the divisor
    for (int l = 0; l < DIV_LANES; l++) begin
      rem_src[0][l] = DIV_REM_W'(in_num[l] >> DIV_STAGES);
      low_src[0][l] = in_num[l][DIV_STAGES-1:0];
      quo_src[0][l] = '0;
      den_src[0][l] = in_den[l];
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      rem_src[k] = rem[k-1];
      low_src[k] = low[k-1];
      quo_src[k] = quo[k-1];
      den_src[k] = den[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        acc[k][l]  = {rem_src[k][l][DIV_REM_W-2:0], low_src[k][l][DIV_STAGES-1]};
        take[k][l] = (acc[k][l] >= DIV_REM_W'(den_src[k][l]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < DIV_STAGES; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int k = 1; k < DIV_STAGES; k++) side[k] <= side[k-1];
      for (int k = 0; k < DIV_STAGES; k++) begin
        den[k] <= den_src[k];
        for (int l = 0; l < DIV_LANES; l++) begin
          rem[k][l] <= take[k][l] ? (acc[k][l] - DIV_REM_W'(den_src[k][l])) : acc[k][l];
          low[k][l] <= {low_src[k][l][DIV_STAGES-2:0], 1'b0};
          quo[k][l] <= {quo_src[k][l][DIV_STAGES-2:0], take[k][l]};
        end
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign out_quo   = quo[DIV_STAGES-1];
  assign out_side  = side[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/cpcr_resp.sv -----
// Contact response back end: normal, push-out, relative velocity, bias and impulse.
// Eight register stages; the last is the output register. Depends on cpcr_pkg.
`default_nettype none

module cpcr_resp (
  input  logic                                                      clk,
  input  logic                                                      rst,
  input  logic                                                      en,
  input  logic                                                      in_valid,
  input  logic [cpcr_pkg::DIV_LANES-1:0][cpcr_pkg::DIV_STAGES-1:0]  in_quo,
  input  cpcr_pkg::cpcr_cont_t                                      in_side,
  input  logic [cpcr_pkg::CFG_W-1:0]                                restitution_gain,
  input  logic [cpcr_pkg::CFG_W-1:0]                                bias_gain,
  output logic                                                      out_valid,
  output cpcr_pkg::cpcr_result_t                                    out_res
);
  import cpcr_pkg::*;

  localparam int RESP_STAGES = 8;

  logic [RESP_STAGES-1:0] vld;

  // stage 1: normal components and mass fractions
  logic [DIV_STAGES-1:0]    qx, qy;
  logic [NMAG_W-1:0]        nxm_c, nym_c;
  cpcr_flags_t              f1, f2, f3, f4, f5, f6, f7;
  cpcr_body_t               b1, b2, b3, b4, b5, b6, b7;
  logic signed [NMAG_W:0]   nx1, ny1;
  logic [NMAG_W-1:0]        nxm1, nym1, nxm2, nym2, nxm3, nym3, nxm4, nym4, nxm5, nym5;
  logic [NMAG_W-1:0]        nxm6, nym6;
  logic [NMAG_W-1:0]        fa1, fb1, fa2, fb2, fa3, fb3, fa4, fb4;
  logic [33:0]              penm1;
  cpcr_flags_t              f1_c;

  // stage 2
  logic signed [32:0]       dvx_c, dvy_c;
  logic [50:0]              pcx2, pcy2;
  logic signed [50:0]       prx2, pry2;
  logic [57:0]              pbg2;

  // stage 3
  logic [33:0]              cxm_c, cym_c;
  logic signed [34:0]       cx_c, cy_c;
  logic                     moved_c;
  cpcr_body_t               b3_c;
  cpcr_flags_t              f3_c;
  logic signed [51:0]       sum_c;
  logic [51:0]              smag_c;
  logic [35:0]              relm_c;
  logic signed [36:0]       rel_c, rel3;
  logic [41:0]              biasm3;

  // stage 4
  logic signed [43:0]       bias_c, j_c;
  logic [42:0]              jm4;
  logic                     jneg4, jneg5, jneg6, jneg7;

  // stage 5..7
  logic [59:0]              pa5, pb5;
  logic [67:0]              ta6, tb6;
  logic [51:0]              ua_c, ub_c;
  logic [68:0]              pax7, pay7, pbx7, pby7;

  // stage 8
  logic [52:0]              dax_c, day_c, dbx_c, dby_c;
  logic signed [53:0]       sax_c, say_c, sbx_c, sby_c;
  logic                     imp_c;
  cpcr_result_t             res_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[RESP_STAGES-2:0], in_valid};
    end
  end

  // ---- stage 1
  always_comb begin
    qx    = in_quo[LANE_NX];
    qy    = in_quo[LANE_NY];
    nxm_c = (qx > DIV_STAGES'(Q_ONE)) ? Q_ONE : qx[NMAG_W-1:0];
    nym_c = (qy > DIV_STAGES'(Q_ONE)) ? Q_ONE : qy[NMAG_W-1:0];
    f1_c.zero_dist = in_side.zero_dist;
    f1_c.pen_neg   = in_side.pen[34];
    f1_c.dx_neg    = in_side.dx_neg;
    f1_c.dy_neg    = in_side.dy_neg;
    f1_c.closing   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1    <= in_side.body;
      f1    <= f1_c;
      nxm1  <= nxm_c;
      nym1  <= nym_c;
      nx1   <= in_side.dx_neg ? -$signed({1'b0, nxm_c}) : $signed({1'b0, nxm_c});
      ny1   <= in_side.dy_neg ? -$signed({1'b0, nym_c}) : $signed({1'b0, nym_c});
      penm1 <= in_side.pen[34] ? 34'(-in_side.pen) : 34'(in_side.pen);
      fa1   <= in_side.msum_zero ? '0 : in_quo[LANE_FA][NMAG_W-1:0];
      fb1   <= in_side.msum_zero ? '0 : in_quo[LANE_FB][NMAG_W-1:0];
    end
  end

  // ---- stage 2: products
  assign dvx_c = $signed({b1.avx[31], b1.avx}) - $signed({b1.bvx[31], b1.bvx});
  assign dvy_c = $signed({b1.avy[31], b1.avy}) - $signed({b1.bvy[31], b1.bvy});

  always_ff @(posedge clk) begin
    if (en) begin
      b2   <= b1;
      f2   <= f1;
      nxm2 <= nxm1;
      nym2 <= nym1;
      fa2  <= fa1;
      fb2  <= fb1;
      pcx2 <= penm1 * nxm1;
      pcy2 <= penm1 * nym1;
      prx2 <= dvx_c * nx1;
      pry2 <= dvy_c * ny1;
      pbg2 <= penm1 * bias_gain;
    end
  end

  // ---- stage 3: push-out, relative normal velocity, bias magnitude
  always_comb begin
    cxm_c   = pcx2[50:17];
    cym_c   = pcy2[50:17];
    cx_c    = (f2.pen_neg ^ f2.dx_neg) ? -$signed({1'b0, cxm_c}) : $signed({1'b0, cxm_c});
    cy_c    = (f2.pen_neg ^ f2.dy_neg) ? -$signed({1'b0, cym_c}) : $signed({1'b0, cym_c});
    moved_c = f2.pen_neg & ~f2.zero_dist;
    b3_c    = b2;
    if (moved_c) begin
      b3_c.apx = sat32(64'($signed(b2.apx)) - 64'(cx_c));
      b3_c.apy = sat32(64'($signed(b2.apy)) - 64'(cy_c));
      b3_c.bpx = sat32(64'($signed(b2.bpx)) + 64'(cx_c));
      b3_c.bpy = sat32(64'($signed(b2.bpy)) + 64'(cy_c));
    end
    // dot product scaled down, truncated toward zero
    sum_c  = 52'(prx2) + 52'(pry2);
    smag_c = sum_c[51] ? 52'(-sum_c) : 52'(sum_c);
    relm_c = smag_c[51:16];
    rel_c  = sum_c[51] ? -$signed({1'b0, relm_c}) : $signed({1'b0, relm_c});
    f3_c         = f2;
    f3_c.closing = rel_c[36];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3     <= b3_c;
      f3     <= f3_c;
      nxm3   <= nxm2;
      nym3   <= nym2;
      fa3    <= fa2;
      fb3    <= fb2;
      rel3   <= rel_c;
      biasm3 <= pbg2[57:16];
    end
  end

  // ---- stage 4: biased impulse j
  always_comb begin
    bias_c = f3.pen_neg ? -$signed({2'b00, biasm3}) : $signed({2'b00, biasm3});
    j_c    = 44'(rel3) + bias_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b4    <= b3;
      f4    <= f3;
      nxm4  <= nxm3;
      nym4  <= nym3;
      fa4   <= fa3;
      fb4   <= fb3;
      jm4   <= j_c[43] ? 43'(-j_c) : 43'(j_c);
      jneg4 <= j_c[43];
    end
  end

  // ---- stage 5: j times mass fraction
  always_ff @(posedge clk) begin
    if (en) begin
      b5    <= b4;
      f5    <= f4;
      nxm5  <= nxm4;
      nym5  <= nym4;
      jneg5 <= jneg4;
      pa5   <= jm4 * fa4;
      pb5   <= jm4 * fb4;
    end
  end

  // ---- stage 6: times restitution
  always_ff @(posedge clk) begin
    if (en) begin
      b6    <= b5;
      f6    <= f5;
      nxm6  <= nxm5;
      nym6  <= nym5;
      jneg6 <= jneg5;
      ta6   <= pa5[59:16] * restitution_gain;
      tb6   <= pb5[59:16] * restitution_gain;
    end
  end

  // ---- stage 7: along the normal
  assign ua_c = ta6[67:16];
  assign ub_c = tb6[67:16];

  always_ff @(posedge clk) begin
    if (en) begin
      b7    <= b6;
      f7    <= f6;
      jneg7 <= jneg6;
      pax7  <= ua_c * nxm6;
      pay7  <= ua_c * nym6;
      pbx7  <= ub_c * nxm6;
      pby7  <= ub_c * nym6;
    end
  end

  // ---- stage 8: velocity update, output register
  always_comb begin
    dax_c = pax7[68:16];
    day_c = pay7[68:16];
    dbx_c = pbx7[68:16];
    dby_c = pby7[68:16];
    sax_c = (jneg7 ^ f7.dx_neg) ? -$signed({1'b0, dax_c}) : $signed({1'b0, dax_c});
    say_c = (jneg7 ^ f7.dy_neg) ? -$signed({1'b0, day_c}) : $signed({1'b0, day_c});
    sbx_c = (jneg7 ^ f7.dx_neg) ? -$signed({1'b0, dbx_c}) : $signed({1'b0, dbx_c});
    sby_c = (jneg7 ^ f7.dy_neg) ? -$signed({1'b0, dby_c}) : $signed({1'b0, dby_c});
    imp_c = f7.pen_neg & ~f7.zero_dist & f7.closing;
    res_c.body        = b7;
    res_c.overlapping = f7.pen_neg | f7.zero_dist;
    res_c.impulse     = imp_c;
    if (imp_c) begin
      res_c.body.avx = sat32(64'($signed(b7.avx)) - 64'(sax_c));
      res_c.body.avy = sat32(64'($signed(b7.avy)) - 64'(say_c));
      res_c.body.bvx = sat32(64'($signed(b7.bvx)) + 64'(sbx_c));
      res_c.body.bvy = sat32(64'($signed(b7.bvy)) + 64'(sby_c));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= res_c;
    end
  end

  assign out_valid = vld[RESP_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/circle_pair_collision_response.sv -----
// Circle pair collision response, Q16.16, fully pipelined.
// Throughput: one pair per cycle; the whole pipeline holds while a result is stalled.
// Timing is set by the front stages, the 32-stage square root, stage E, the 18-stage divider lanes and the back end.
// Reset (rst, synchronous): clears all valid bits and reloads the register defaults.
`default_nettype none

module circle_pair_collision_response (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            a_pos_x,
  input  logic signed [31:0]            a_pos_y,
  input  logic signed [31:0]            a_vel_x,
  input  logic signed [31:0]            a_vel_y,
  input  logic [30:0]                   a_radius,
  input  logic [30:0]                   a_mass,
  input  logic signed [31:0]            b_pos_x,
  input  logic signed [31:0]            b_pos_y,
  input  logic signed [31:0]            b_vel_x,
  input  logic signed [31:0]            b_vel_y,
  input  logic [30:0]                   b_radius,
  input  logic [30:0]                   b_mass,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            new_a_pos_x,
  output logic signed [31:0]            new_a_pos_y,
  output logic signed [31:0]            new_a_vel_x,
  output logic signed [31:0]            new_a_vel_y,
  output logic signed [31:0]            new_b_pos_x,
  output logic signed [31:0]            new_b_pos_y,
  output logic signed [31:0]            new_b_vel_x,
  output logic signed [31:0]            new_b_vel_y,
  output logic                          overlapping,
  output logic                          impulse_applied,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [cpcr_pkg::CFG_W-1:0]    cfg_data
);
  import cpcr_pkg::*;

  logic [CFG_W-1:0] contact_slop, restitution_gain, bias_gain;
  logic             adv;

  // front stages
  logic               va, vb, vc, ve;
  cpcr_geom_t         geom_in_c, geom_a, geom_b, geom_c;
  logic signed [32:0] dx_c, dy_c;
  logic [32:0]        ux_c, uy_c;
  logic [31:0]        hx_c, hy_c;
  logic [63:0]        sqx_b, sqy_b;
  logic [63:0]        rad_c;

  // square root
  logic               sq_valid;
  logic [ROOT_W-1:0]  sq_root;
  cpcr_geom_t         sq_side;

  // setup for division
  logic [32:0]                          dist_c, msum_c;
  logic signed [34:0]                   pen_c;
  cpcr_cont_t                           cont_c, cont_e;
  logic [DIV_LANES-1:0][DIV_NUM_W-1:0]  num_e;
  logic [DIV_LANES-1:0][DIV_DEN_W-1:0]  den_e;

  logic                                 dv_valid;
  logic [DIV_LANES-1:0][DIV_STAGES-1:0] dv_quo;
  cpcr_cont_t                           dv_side;

  cpcr_result_t                         res;

  assign adv       = ~(out_valid & out_stall);
  assign in_stall  = ~adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      contact_slop     <= CONTACT_SLOP_RST;
      restitution_gain <= RESTITUTION_GAIN_RST;
      bias_gain        <= BIAS_GAIN_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CONTACT_SLOP:     contact_slop     <= cfg_data;
        REG_RESTITUTION_GAIN: restitution_gain <= cfg_data;
        REG_BIAS_GAIN:        bias_gain        <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- stage A: center difference and range shift
  always_comb begin
    dx_c = $signed({a_pos_x[31], a_pos_x}) - $signed({b_pos_x[31], b_pos_x});
    dy_c = $signed({a_pos_y[31], a_pos_y}) - $signed({b_pos_y[31], b_pos_y});
    ux_c = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
    uy_c = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
    geom_in_c.body.apx = a_pos_x;
    geom_in_c.body.apy = a_pos_y;
    geom_in_c.body.avx = a_vel_x;
    geom_in_c.body.avy = a_vel_y;
    geom_in_c.body.bpx = b_pos_x;
    geom_in_c.body.bpy = b_pos_y;
    geom_in_c.body.bvx = b_vel_x;
    geom_in_c.body.bvy = b_vel_y;
    geom_in_c.rsum     = {2'b00, a_radius} + {2'b00, b_radius};
    geom_in_c.am       = a_mass;
    geom_in_c.bm       = b_mass;
    geom_in_c.ux       = ux_c;
    geom_in_c.uy       = uy_c;
    geom_in_c.dx_neg   = dx_c[32];
    geom_in_c.dy_neg   = dy_c[32];
    // if either magnitude is 2^31 or more, both are halved before squaring
    geom_in_c.shift    = ux_c[32] | ux_c[31] | uy_c[32] | uy_c[31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      ve <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      ve <= sq_valid;
    end
  end

  // ---- stage B: squares; stage C: sum of squares
  assign hx_c = geom_a.shift ? geom_a.ux[32:1] : geom_a.ux[31:0];
  assign hy_c = geom_a.shift ? geom_a.uy[32:1] : geom_a.uy[31:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      geom_a <= geom_in_c;
      geom_b <= geom_a;
      sqx_b  <= hx_c * hx_c;
      sqy_b  <= hy_c * hy_c;
      geom_c <= geom_b;
      rad_c  <= sqx_b + sqy_b;
    end
  end

  cpcr_sqrt u_sqrt (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .in_valid    (vc),
    .in_radicand (rad_c),
    .in_side     (geom_c),
    .out_valid   (sq_valid),
    .out_root    (sq_root),
    .out_side    (sq_side)
  );

  // ---- stage E: distance, penetration, divider operands
  always_comb begin
    dist_c = sq_side.shift ? {sq_root, 1'b0} : {1'b0, sq_root};
    pen_c  = $signed({2'b00, dist_c}) - $signed({2'b00, sq_side.rsum})
           + $signed({11'd0, contact_slop});
    msum_c = {2'b00, sq_side.am} + {2'b00, sq_side.bm};
    cont_c.body      = sq_side.body;
    cont_c.pen       = pen_c;
    cont_c.zero_dist = (dist_c == '0);
    cont_c.dx_neg    = sq_side.dx_neg;
    cont_c.dy_neg    = sq_side.dy_neg;
    cont_c.msum_zero = (msum_c == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cont_e         <= cont_c;
      num_e[LANE_NX] <= {sq_side.ux, 16'd0};
      num_e[LANE_NY] <= {sq_side.uy, 16'd0};
      num_e[LANE_FA] <= {2'b00, sq_side.am, 16'd0};
      num_e[LANE_FB] <= {2'b00, sq_side.bm, 16'd0};
      den_e[LANE_NX] <= dist_c;
      den_e[LANE_NY] <= dist_c;
      den_e[LANE_FA] <= msum_c;
      den_e[LANE_FB] <= msum_c;
    end
  end

  cpcr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (ve),
    .in_num    (num_e),
    .in_den    (den_e),
    .in_side   (cont_e),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  cpcr_resp u_resp (
    .clk              (clk),
    .rst              (rst),
    .en               (adv),
    .in_valid         (dv_valid),
    .in_quo           (dv_quo),
    .in_side          (dv_side),
    .restitution_gain (restitution_gain),
    .bias_gain        (bias_gain),
    .out_valid        (out_valid),
    .out_res          (res)
  );

  assign new_a_pos_x     = res.body.apx;
  assign new_a_pos_y     = res.body.apy;
  assign new_a_vel_x     = res.body.avx;
  assign new_a_vel_y     = res.body.avy;
  assign new_b_pos_x     = res.body.bpx;
  assign new_b_pos_y     = res.body.bpy;
  assign new_b_vel_x     = res.body.bvx;
  assign new_b_vel_y     = res.body.bvy;
  assign overlapping     = res.overlapping;
  assign impulse_applied = res.impulse;

`ifndef NO_ASSERTIONS
  a_impulse_needs_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!impulse_applied || overlapping))
    else $error("impulse reported without overlap");

  a_reset_empties_pipe: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> (out_valid && $stable(new_a_vel_x) && $stable(impulse_applied)))
    else $error("pipeline moved while output stalled");
`endif

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for circle_pair_collision_response: a queue-fed request driver,
// a checking monitor and a bit-exact Q16.16 predictor of the contact response.
// Depends on rtl/cpcr_pkg.sv and rtl/circle_pair_collision_response.sv.
`timescale 1ns / 1ps

module tb;
  import cpcr_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 80;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic signed [31:0] apx, apy, avx, avy, bpx, bpy, bvx, bvy;
    logic [30:0] ar, am, br, bm;
  } pair_t;

  typedef struct {
    logic signed [31:0] apx, apy, avx, avy, bpx, bpy, bvx, bvy;
    logic ovl, imp;
  } resp_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] a_pos_x = 0, a_pos_y = 0, a_vel_x = 0, a_vel_y = 0;
  logic signed [31:0] b_pos_x = 0, b_pos_y = 0, b_vel_x = 0, b_vel_y = 0;
  logic [30:0] a_radius = 0, a_mass = 0, b_radius = 0, b_mass = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y;
  logic signed [31:0] new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y;
  logic overlapping, impulse_applied;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = 0;

  circle_pair_collision_response dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // predictor's copy of the registers
  logic [CFG_W-1:0] slop_r = CONTACT_SLOP_RST;
  logic [CFG_W-1:0] rgain_r = RESTITUTION_GAIN_RST;
  logic [CFG_W-1:0] bgain_r = BIAS_GAIN_RST;

  pair_t pend_q[$];
  resp_t resp_q[$];
  int errors = 0, n_in = 0, n_out = 0, n_ovl = 0, n_imp = 0, n_cfg = 0;
  bit hold_req = 0;
  int cyc = 0;

  always @(posedge clk) cyc <= cyc + 1;

  // one stretch of cyc in every four draws no random gaps or stalls
  function automatic bit quiet();
    return ((cyc / 256) % 4) == 1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet() || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Q16.16 product, truncated toward zero
  function automatic longint qmul(longint a, longint b);
    longint unsigned ua, ub, r;
    ua = absv(a);
    ub = absv(b);
    r = (ua >> 16) * ub + (((ua & 64'hFFFF) * ub) >> 16);
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip_unit(longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic resp_t contact_response(pair_t p);
    longint apx, apy, avx, avy, bpx, bpy, bvx, bvy, ar, am, br, bm;
    longint dx, dy, dlen, pen, nx, ny, cx, cy, rel, j, fa, fb, ua, ub;
    longint unsigned ux, uy, msum;
    int s;
    resp_t r;
    apx = p.apx; apy = p.apy; avx = p.avx; avy = p.avy;
    bpx = p.bpx; bpy = p.bpy; bvx = p.bvx; bvy = p.bvy;
    ar = longint'(p.ar); am = longint'(p.am); br = longint'(p.br); bm = longint'(p.bm);
    dx = apx - bpx;
    dy = apy - bpy;
    ux = absv(dx);
    uy = absv(dy);
    s = (ux >= 64'h8000_0000 || uy >= 64'h8000_0000) ? 1 : 0;
    ux >>= s;
    uy >>= s;
    dlen = longint'(root64(ux * ux + uy * uy) << s);
    pen = dlen - (ar + br - longint'(slop_r));
    r.ovl = 0;
    r.imp = 0;
    if (dlen == 0) begin
      r.ovl = 1;
    end else if (pen < 0) begin
      nx = clip_unit((dx * 65536) / dlen);
      ny = clip_unit((dy * 65536) / dlen);
      cx = qmul(pen, nx) / 2;
      cy = qmul(pen, ny) / 2;
      rel = ((avx - bvx) * nx + (avy - bvy) * ny) / 65536;
      r.ovl = 1;
      apx -= cx; apy -= cy;
      bpx += cx; bpy += cy;
      if (rel < 0) begin
        j = rel + qmul(pen, longint'(bgain_r));
        msum = am + bm;
        fa = 0;
        fb = 0;
        if (msum != 0) begin
          fa = (am << 16) / msum;
          fb = (bm << 16) / msum;
        end
        ua = qmul(qmul(j, fa), longint'(rgain_r));
        ub = qmul(qmul(j, fb), longint'(rgain_r));
        avx -= qmul(ua, nx); avy -= qmul(ua, ny);
        bvx += qmul(ub, nx); bvy += qmul(ub, ny);
        r.imp = 1;
      end
    end
    r.apx = clip32(apx); r.apy = clip32(apy); r.avx = clip32(avx); r.avy = clip32(avy);
    r.bpx = clip32(bpx); r.bpy = clip32(bpy); r.bvx = clip32(bvx); r.bvy = clip32(bvy);
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    bit fire;
    int gap;
    if (rst) begin
      in_valid <= 0;
      gap = 0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) begin
        resp_q.push_back(contact_response(pend_q.pop_front()));
        n_in++;
      end
      if (in_valid && !fire) begin
        // stalled request holds
      end else if (gap > 0) begin
        gap--;
        in_valid <= 0;
      end else if (pend_q.size() > 0) begin
        a_pos_x <= pend_q[0].apx; a_pos_y <= pend_q[0].apy;
        a_vel_x <= pend_q[0].avx; a_vel_y <= pend_q[0].avy;
        a_radius <= pend_q[0].ar; a_mass <= pend_q[0].am;
        b_pos_x <= pend_q[0].bpx; b_pos_y <= pend_q[0].bpy;
        b_vel_x <= pend_q[0].bvx; b_vel_y <= pend_q[0].bvy;
        b_radius <= pend_q[0].br; b_mass <= pend_q[0].bm;
        in_valid <= 1;
        gap = pick_gap();
      end else begin
        in_valid <= 0;
      end
    end
  end

  task automatic cmp(string f, logic signed [31:0] e, logic signed [31:0] a);
    if (e !== a) begin
      errors++;
      if (errors <= 10)
        $display("mismatch result %0d %s: expected %0d, got %0d", n_out, f, e, a);
    end
  endtask

  // result monitor and receiver stalls
  always @(posedge clk) begin
    resp_t e;
    int stall_cnt, hold_cnt;
    bit hold_done;
    if (rst) begin
      out_stall <= 0;
      stall_cnt = 0;
      hold_cnt = 0;
      hold_done = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (resp_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("mismatch: result %0d with no request pending", n_out);
        end else begin
          e = resp_q.pop_front();
          cmp("new_a_pos_x", e.apx, new_a_pos_x);
          cmp("new_a_pos_y", e.apy, new_a_pos_y);
          cmp("new_a_vel_x", e.avx, new_a_vel_x);
          cmp("new_a_vel_y", e.avy, new_a_vel_y);
          cmp("new_b_pos_x", e.bpx, new_b_pos_x);
          cmp("new_b_pos_y", e.bpy, new_b_pos_y);
          cmp("new_b_vel_x", e.bvx, new_b_vel_x);
          cmp("new_b_vel_y", e.bvy, new_b_vel_y);
          cmp("overlapping", e.ovl, overlapping);
          cmp("impulse_applied", e.imp, impulse_applied);
          n_ovl += e.ovl;
          n_imp += e.imp;
        end
        n_out++;
      end
      if (hold_cnt == 0 && hold_req && !hold_done) begin
        hold_cnt = LONG_HOLD;
        hold_done = 1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall <= 1;
      end else begin
        stall_cnt = pick_gap();
        out_stall <= (stall_cnt > 0);
        if (stall_cnt > 0) stall_cnt--;
      end
    end
  end

  // watchdog: cycles with no handshake at all
  always @(posedge clk) begin
    int idle;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle = 0;
    end else begin
      idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_CONTACT_SLOP:     slop_r = val;
      REG_RESTITUTION_GAIN: rgain_r = val;
      REG_BIAS_GAIN:        bgain_r = val;
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic add_pair(int apx, int apy, int avx, int avy, int ar, int am,
                          int bpx, int bpy, int bvx, int bvy, int br, int bm);
    pair_t p;
    p.apx = apx; p.apy = apy; p.avx = avx; p.avy = avy;
    p.ar = 31'(ar); p.am = 31'(am);
    p.bpx = bpx; p.bpy = bpy; p.bvx = bvx; p.bvy = bvy;
    p.br = 31'(br); p.bm = 31'(bm);
    pend_q.push_back(p);
  endtask

  function automatic int offs(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly near contacts with random content; some raw noise and coincident centres
  task automatic add_random_pair();
    pair_t p;
    int mode, span, vspan;
    mode = $urandom_range(0, 9);
    span = 1 << (8 + 4 * $urandom_range(0, 4));
    vspan = ($urandom_range(0, 3) == 0) ? 32'h7fff_ffff : (1 << $urandom_range(4, 24));
    if (mode == 0) begin
      p.apx = $urandom; p.apy = $urandom; p.avx = $urandom; p.avy = $urandom;
      p.bpx = $urandom; p.bpy = $urandom; p.bvx = $urandom; p.bvy = $urandom;
      p.ar = 31'($urandom); p.am = 31'($urandom);
      p.br = 31'($urandom); p.bm = 31'($urandom);
    end else begin
      p.apx = offs(1 << 28); p.apy = offs(1 << 28);
      p.bpx = (mode == 9) ? p.apx : p.apx + offs(span);
      p.bpy = (mode == 9) ? p.apy : p.apy + offs(span);
      p.avx = offs(vspan); p.avy = offs(vspan);
      p.bvx = offs(vspan); p.bvy = offs(vspan);
      p.ar = 31'($urandom_range(0, span)); p.br = 31'($urandom_range(0, span));
      p.am = ($urandom_range(0, 7) == 0) ? 31'd0 : 31'($urandom_range(0, 1 << 24));
      p.bm = ($urandom_range(0, 7) == 0) ? 31'd0 : 31'($urandom_range(0, 1 << 24));
    end
    pend_q.push_back(p);
  endtask

  task automatic drain();
    do @(posedge clk); while (pend_q.size() != 0 || resp_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  localparam int ONE = 65536;
  localparam int PMAX = 32'h7fff_ffff;
  localparam int PMIN = 32'h8000_0000;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;

    // directed: defaults of the registers
    add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);                       // coincident
    add_pair(5, -7, 3, 3, ONE, ONE, 5, -7, -3, 1, ONE, ONE);             // coincident, moving
    add_pair(0, 0, 0, 0, ONE, ONE, 100 * ONE, 0, 0, 0, ONE, ONE);        // far apart
    add_pair(0, 0, ONE, 0, ONE, ONE, ONE, 0, -ONE, 0, ONE, ONE);         // closing
    add_pair(0, 0, -ONE, 0, ONE, ONE, ONE, 0, ONE, 0, ONE, ONE);         // separating
    add_pair(0, 0, ONE, 0, ONE, 0, ONE, 0, -ONE, 0, ONE, 0);             // zero mass sum
    add_pair(0, 0, 0, ONE, 2 * ONE, 3 * ONE, ONE, ONE, 0, -ONE, ONE, ONE);
    add_pair(0, 0, 0, 0, ONE, ONE, 2 * ONE - 72090, 0, 0, 0, ONE, ONE);  // just touching
    add_pair(PMAX, PMAX, 0, 0, PMAX, PMAX, PMIN, PMIN, 0, 0, PMAX, PMAX);
    add_pair(PMAX, PMIN, PMAX, PMIN, PMAX, 0, PMIN, PMAX, PMIN, PMAX, PMAX, PMAX);
    add_pair(PMAX, 0, PMAX, PMAX, PMAX, PMAX, PMAX - ONE, 0, PMIN, PMIN, PMAX, PMAX);
    add_pair(PMIN, PMIN, PMIN, PMIN, PMAX, 0, PMIN + 3, PMIN + 5, PMAX, PMAX, 0, PMAX);
    add_pair(-ONE, -ONE, PMAX, PMAX, 0, PMAX, 0, 0, PMIN, PMIN, 0, 0);
    add_pair(0, 0, -1, 0, PMAX, 1, 1, 0, 1, 0, PMAX, 1);
    drain();

    // extremes of the registers, plus a write to the unused index
    write_reg(REG_CONTACT_SLOP, 0);
    write_reg(REG_RESTITUTION_GAIN, 24'hFF_FFFF);
    write_reg(REG_BIAS_GAIN, 0);
    write_reg(REG_UNUSED, 24'hAB_CDEF);
    hold_req = 1;
    repeat (150) add_random_pair();
    drain();

    write_reg(REG_CONTACT_SLOP, 24'hFF_FFFF);
    write_reg(REG_RESTITUTION_GAIN, 0);
    write_reg(REG_BIAS_GAIN, 24'hFF_FFFF);
    repeat (100) add_random_pair();
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_CONTACT_SLOP, $urandom_range(0, 24'hFF_FFFF));
      write_reg(REG_RESTITUTION_GAIN, $urandom_range(0, 24'hFF_FFFF));
      write_reg(REG_BIAS_GAIN, $urandom_range(0, 1 << ($urandom_range(0, 6) * 4)));
      repeat (100) add_random_pair();
      drain();
    end

    $display("covered %0d pairs (%0d overlapping, %0d with impulse) over %0d register writes",
             n_in, n_ovl, n_imp, n_cfg);
    $display("results checked: %0d, mismatches: %0d", n_out, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
